>>> rtl/parent_array_tree_table_core_assert.svh
// Assertion macros for the checker in pat_chk.sv.
`ifndef PARENT_ARRAY_TREE_TABLE_CORE_ASSERT_SVH
`define PARENT_ARRAY_TREE_TABLE_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PAT_ASSERT_SAME(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PAT_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/pat_pkg.sv
package pat_pkg;

  localparam int SLOTS  = 64;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);

  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_BAD  = 2'd1;
  localparam logic [1:0] STS_NONE = 2'd2;

  localparam logic [6:0] REF_NONE = 7'h7f;
  localparam logic [7:0] CUR_NONE = 8'hff;

  typedef enum logic [2:0] {
    FN_ADD     = 3'd0,
    FN_PRUNE   = 3'd1,
    FN_SUBTREE = 3'd2,
    FN_CHILD   = 3'd3,
    FN_PARENT  = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_MARK,
    ST_CHILD,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [7:0]  cursor;
    logic [31:0] elem_id;
    logic [6:0]  node_ref;
    logic [2:0]  func;
  } req_t;

  typedef struct packed {
    logic [7:0] next_cursor;
    logic [6:0] node_count;
    logic [6:0] ref_out;
    logic [1:0] status;
  } res_t;

  typedef struct packed {
    logic [31:0]       elem;
    logic [SLOT_W-1:0] parent;
  } node_word_t;

  function automatic logic [6:0] sat_count(input logic [CNT_W-1:0] c);
    if (int'(c) > 127) begin
      return 7'h7f;
    end
    return 7'(c);
  endfunction

endpackage

>>> rtl/pat_mem.sv
module pat_mem (
  input  logic                       clk,
  input  logic                       we,
  input  logic [pat_pkg::SLOT_W-1:0] waddr,
  input  pat_pkg::node_word_t        wdata,
  input  logic [pat_pkg::SLOT_W-1:0] raddr,
  output pat_pkg::node_word_t        rdata
);
  import pat_pkg::*;

  node_word_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/pat_ctrl.sv
module pat_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  pat_pkg::req_t              req,
  output logic                       idle,
  output logic                       res_valid,
  input  logic                       res_ready,
  output pat_pkg::res_t              res,
  output logic                       we,
  output logic [pat_pkg::SLOT_W-1:0] waddr,
  output pat_pkg::node_word_t        wdata,
  output logic [pat_pkg::SLOT_W-1:0] raddr,
  input  pat_pkg::node_word_t        rdata
);
  import pat_pkg::*;

  localparam logic [SLOT_W-1:0] LAST = SLOT_W'(SLOTS - 1);

  state_t            state, state_next;
  logic [SLOT_W-1:0] idx, idx_next;
  logic              chg, chg_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [CNT_W-1:0]  occ, occ_next;
  logic [SLOTS-1:0]  used, used_next;
  logic [SLOTS-1:0]  in_set, in_set_next;
  req_t              cur, cur_next;
  res_t              res_next;

  logic [SLOT_W-1:0] node_i;
  logic [SLOT_W-1:0] cur_i;
  logic              node_ok;
  logic              cursor_ok;
  logic              hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      used  <= '0;
      occ   <= '0;
    end else begin
      state <= state_next;
      used  <= used_next;
      occ   <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    idx    <= idx_next;
    chg    <= chg_next;
    cnt    <= cnt_next;
    in_set <= in_set_next;
    cur    <= cur_next;
    res    <= res_next;
  end

  assign idle      = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);
  assign raddr     = idx_next;
  assign node_i    = SLOT_W'(req.node_ref);
  assign cur_i     = SLOT_W'(req.cursor[6:0]);
  assign node_ok   = (int'(req.node_ref) < SLOTS);
  assign cursor_ok = !req.cursor[7] && (int'(req.cursor[6:0]) < SLOTS);
  assign hit       = used[idx] && !in_set[idx] && in_set[rdata.parent];

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    chg_next    = chg;
    cnt_next    = cnt;
    occ_next    = occ;
    used_next   = used;
    in_set_next = in_set;
    cur_next    = cur;
    res_next    = res;
    we          = 1'b0;
    waddr       = idx;
    wdata       = '{elem: cur.elem_id, parent: SLOT_W'(cur.node_ref)};

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cur_next = req;
          res_next = '{next_cursor: 8'd0, node_count: 7'd0,
                       ref_out: REF_NONE, status: STS_BAD};
          state_next = ST_DONE;
          unique case (func_t'(req.func))
            FN_ADD: begin
              if (node_ok && (int'(occ) < SLOTS) && (used[node_i] || occ == '0)) begin
                idx_next   = '0;
                state_next = ST_ADD;
              end
            end
            FN_PRUNE, FN_SUBTREE: begin
              if (node_ok) begin
                res_next.status = STS_OK;
                if (used[node_i]) begin
                  in_set_next         = '0;
                  in_set_next[node_i] = 1'b1;
                  cnt_next            = CNT_W'(1);
                  chg_next            = 1'b0;
                  idx_next            = '0;
                  state_next          = ST_MARK;
                end
              end
            end
            FN_CHILD: begin
              res_next.next_cursor = req.cursor;
              if (cursor_ok && node_ok && used[node_i]) begin
                res_next.status      = STS_NONE;
                res_next.next_cursor = CUR_NONE;
                idx_next             = cur_i;
                state_next           = ST_CHILD;
              end
            end
            FN_PARENT: begin
              if (node_ok && used[node_i]) begin
                idx_next   = node_i;
                state_next = ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_ADD: begin
        if (!used[idx]) begin
          we               = 1'b1;
          used_next[idx]   = 1'b1;
          occ_next         = occ + CNT_W'(1);
          res_next.status  = STS_OK;
          res_next.ref_out = 7'(idx);
          state_next       = ST_DONE;
        end else begin
          idx_next = idx + SLOT_W'(1);
        end
      end

      ST_MARK: begin
        if (hit) begin
          in_set_next[idx] = 1'b1;
          cnt_next         = cnt + CNT_W'(1);
        end
        if (idx == LAST) begin
          if (chg || hit) begin
            idx_next = '0;
            chg_next = 1'b0;
          end else begin
            res_next.node_count = sat_count(cnt);
            if (func_t'(cur.func) == FN_PRUNE) begin
              used_next = used & ~in_set;
              occ_next  = (occ >= cnt) ? occ - cnt : '0;
            end
            state_next = ST_DONE;
          end
        end else begin
          idx_next = idx + SLOT_W'(1);
          if (hit) begin
            chg_next = 1'b1;
          end
        end
      end

      ST_CHILD: begin
        if (used[idx] && rdata.parent == SLOT_W'(cur.node_ref)) begin
          res_next.status      = STS_OK;
          res_next.ref_out     = 7'(idx);
          res_next.next_cursor = 8'({1'b0, idx} + (SLOT_W + 1)'(1));
          state_next           = ST_DONE;
        end else if (idx == LAST) begin
          state_next = ST_DONE;
        end else begin
          idx_next = idx + SLOT_W'(1);
        end
      end

      ST_READ: begin
        res_next.status  = STS_OK;
        res_next.ref_out = 7'(rdata.parent);
        state_next       = ST_DONE;
      end

      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/parent_array_tree_table_core.sv
// Channel  Direction  tdata fields, lowest bit first
// s_axis   in         func[2:0], node_ref[9:3], elem_id[41:10], cursor[49:42], zero fill
// m_axis   out        status[1:0], ref_out[8:2], node_count[15:9], next_cursor[23:16]
//
// One request is worked on at a time; s_axis_tready is high only while the sequencer idles.
// Add and next child scan the slots in order, up to 64; prune and subtree size pass over
// the whole parent memory and need at most one pass more than the depth of the subtree.
// Reset is synchronous and frees all slots at once; a finished result waits in the output
// register while the next request is worked on; the next result waits until it is taken.
module parent_array_tree_table_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // func, node_ref, elem_id, cursor, zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // status, ref_out, node_count, next_cursor
);
  import pat_pkg::*;

  req_t              req;
  res_t              res;
  logic              idle;
  logic              res_valid;
  logic              res_ready;
  logic              we;
  logic [SLOT_W-1:0] waddr;
  logic [SLOT_W-1:0] raddr;
  node_word_t        wdata;
  node_word_t        rdata;

  assign req           = s_axis_tdata[49:0];
  assign s_axis_tready = idle;
  assign res_ready     = !m_axis_tvalid || m_axis_tready;

  pat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (s_axis_tvalid && s_axis_tready),
    .req       (req),
    .idle      (idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  pat_mem u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= res;
    end
  end

endmodule

>>> rtl/pat_chk.sv
`include "parent_array_tree_table_core_assert.svh"

module pat_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  import pat_pkg::*;

  logic stall;
  logic acc;
  logic out_bad;
  logic fields_clear;

  assign stall        = m_axis_tvalid && !m_axis_tready;
  assign acc          = s_axis_tvalid && s_axis_tready;
  assign out_bad      = m_axis_tvalid && (m_axis_tdata[1:0] != STS_OK);
  assign fields_clear = (m_axis_tdata[8:2] == REF_NONE) && (m_axis_tdata[15:9] == 7'd0);

  `PAT_ASSERT_NEXT(a_hold, clk, rst, stall, m_axis_tvalid && $stable(m_axis_tdata), "Result moved.")
  `PAT_ASSERT_NEXT(a_busy_after_req, clk, rst, acc, !s_axis_tready, "Request accepted while busy.")
  `PAT_ASSERT_SAME(a_status_code, clk, rst, m_axis_tvalid, m_axis_tdata[1:0] <= STS_NONE, "Bad status.")
  `PAT_ASSERT_SAME(a_fail_fields, clk, rst, out_bad, fields_clear, "Failed result has a slot or count.")

endmodule

bind parent_array_tree_table_core pat_chk u_chk (.*);

>>> dv/pat_table_checker.sv
module pat_table_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  output int unsigned fail_count,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import pat_pkg::*;

  bit                occupied[SLOTS];
  logic [SLOT_W-1:0] up_link[SLOTS];
  logic [31:0]       elem_of[SLOTS];
  int unsigned       live_nodes;
  res_t              awaited_results[$];

  task automatic report_mismatch(input string what);
    $display("%0t ERROR %s", $realtime, what);
    fail_count++;
  endtask

  function automatic res_t apply_table_op(input req_t r);
    res_t        o;
    bit          in_tree[SLOTS];
    bit          grew;
    bit          slot_ok;
    int unsigned tally;
    int          slot;
    int          first;
    o.status      = STS_BAD;
    o.ref_out     = REF_NONE;
    o.node_count  = '0;
    o.next_cursor = '0;
    foreach (in_tree[i]) in_tree[i] = 1'b0;
    slot    = int'(r.node_ref);
    slot_ok = slot < SLOTS;
    first   = int'($signed(r.cursor));
    tally   = 0;
    case (r.func)
      FN_ADD: begin
        if (slot_ok && live_nodes < SLOTS && (live_nodes == 0 || occupied[slot])) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!occupied[i]) begin
              occupied[i] = 1'b1;
              up_link[i]  = SLOT_W'(slot);
              elem_of[i]  = r.elem_id;
              live_nodes++;
              o.status  = STS_OK;
              o.ref_out = 7'(i);
              break;
            end
          end
        end
      end
      FN_PRUNE, FN_SUBTREE: begin
        if (slot_ok) begin
          o.status = STS_OK;
          if (occupied[slot]) begin
            // Each slot joins the set at most once, so parent loops terminate.
            in_tree[slot] = 1'b1;
            tally = 1;
            do begin
              grew = 1'b0;
              for (int i = 0; i < SLOTS; i++) begin
                if (occupied[i] && !in_tree[i] && in_tree[up_link[i]]) begin
                  in_tree[i] = 1'b1;
                  tally++;
                  grew = 1'b1;
                end
              end
            end while (grew);
            if (r.func == FN_PRUNE) begin
              for (int i = 0; i < SLOTS; i++) begin
                if (in_tree[i]) begin
                  occupied[i] = 1'b0;
                  up_link[i]  = '0;
                  elem_of[i]  = '0;
                end
              end
              live_nodes = (live_nodes >= tally) ? live_nodes - tally : 0;
            end
          end
        end
      end
      FN_CHILD: begin
        o.next_cursor = r.cursor;
        if (first >= 0 && first < SLOTS && slot_ok && occupied[slot]) begin
          o.status      = STS_NONE;
          o.next_cursor = CUR_NONE;
          for (int i = first; i < SLOTS; i++) begin
            if (occupied[i] && up_link[i] == SLOT_W'(slot)) begin
              o.status      = STS_OK;
              o.ref_out     = 7'(i);
              o.next_cursor = 8'(i + 1);
              break;
            end
          end
        end
      end
      FN_PARENT: begin
        if (slot_ok && occupied[slot]) begin
          o.status  = STS_OK;
          o.ref_out = 7'(up_link[slot]);
        end
      end
      default: ;
    endcase
    o.node_count = (tally > 127) ? 7'h7f : 7'(tally);
    return o;
  endfunction

  always @(posedge clk) begin : watch
    res_t got;
    res_t want;
    if (rst) begin
      foreach (occupied[i]) begin
        occupied[i] = 1'b0;
        up_link[i]  = '0;
        elem_of[i]  = '0;
      end
      live_nodes = 0;
      awaited_results.delete();
      pending = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = res_t'(m_axis_tdata);
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result %h arrived with no request outstanding", got));
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status mismatch, got %0d expected %0d",
                                      got.status, want.status));
          if (got.ref_out !== want.ref_out)
            report_mismatch($sformatf("ref_out mismatch, got %h expected %h",
                                      got.ref_out, want.ref_out));
          if (got.node_count !== want.node_count)
            report_mismatch($sformatf("node_count mismatch, got %0d expected %0d",
                                      got.node_count, want.node_count));
          if (got.next_cursor !== want.next_cursor)
            report_mismatch($sformatf("next_cursor mismatch, got %h expected %h",
                                      got.next_cursor, want.next_cursor));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        awaited_results.push_back(apply_table_op(req_t'(s_axis_tdata[$bits(req_t)-1:0])));
      pending = awaited_results.size();
    end
  end

endmodule

>>> dv/tb_parent_array_tree_table_core.sv
module tb_parent_array_tree_table_core;
  timeunit 1ns;
  timeprecision 1ps;
  import pat_pkg::*;

  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 100;

  localparam logic [2:0] FN_UNDEF_LO = 3'd5;
  localparam logic [2:0] FN_UNDEF_HI = 3'd7;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet = 0;
  int          issued = 0;
  int          src_idle_pct = 0;
  int          sink_idle_pct = 0;

  parent_array_tree_table_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  pat_table_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_axis_tready = ($urandom_range(0, 99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_req(input logic [2:0] fn, input logic [6:0] node,
                          input logic [31:0] elem, input logic [7:0] cur);
    req_t r;
    r.func     = fn;
    r.node_ref = node;
    r.elem_id  = elem;
    r.cursor   = cur;
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tdata  = {{($bits(s_axis_tdata) - $bits(req_t)){1'b0}}, r};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    issued++;
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [6:0] pick_node();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 7'($urandom_range(0, 15));
    if (roll < 90) return 7'($urandom_range(16, 63));
    return 7'($urandom_range(64, 127));
  endfunction

  function automatic logic [7:0] pick_cursor();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return 8'($urandom_range(0, 63));
    if (roll < 90) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(64, 127));
  endfunction

  function automatic logic [2:0] pick_func();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return FN_ADD;
    if (roll < 45) return FN_PRUNE;
    if (roll < 65) return FN_SUBTREE;
    if (roll < 85) return FN_CHILD;
    if (roll < 95) return FN_PARENT;
    return 3'($urandom_range(FN_UNDEF_LO, FN_UNDEF_HI));
  endfunction

  task automatic run_random(input int count);
    int stop;
    int len;
    int base;
    int p;
    int c;
    stop = issued + count;
    while (issued < stop) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // Parents trail the fill point so that chains and deep trees form.
          base = $urandom_range(0, 1) ? 0 : $urandom_range(0, 40);
          len  = $urandom_range(10, 70);
          for (int k = 0; k < len; k++) begin
            p = base + k - $urandom_range(0, (k < 3) ? k : 3);
            if (p > 63) p = $urandom_range(0, 63);
            send_req(FN_ADD, 7'(p), $urandom(), 8'($urandom_range(0, 255)));
          end
        end
        3, 4, 5, 6: begin
          len = $urandom_range(10, 40);
          for (int k = 0; k < len; k++)
            send_req(pick_func(), pick_node(), $urandom(), pick_cursor());
        end
        7, 8: begin
          p   = $urandom_range(0, 15);
          c   = $urandom_range(0, 3);
          len = $urandom_range(3, 12);
          for (int k = 0; k < len; k++) begin
            send_req(FN_CHILD, 7'(p), $urandom(), 8'(c));
            c = c + $urandom_range(1, 10);
          end
        end
        default: begin
          send_req(FN_PRUNE, 7'($urandom_range(0, 3)), $urandom(), 8'($urandom_range(0, 255)));
        end
      endcase
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    src_idle_pct  = 29;
    sink_idle_pct = 74;

    send_req(FN_CHILD,   7'd0,   32'h0000_0000, 8'd0);
    send_req(FN_PARENT,  7'd0,   32'h0000_0000, 8'd0);
    send_req(FN_PRUNE,   7'd3,   32'h0000_0000, 8'd0);
    send_req(FN_SUBTREE, 7'd127, 32'hffff_ffff, 8'hff);
    send_req(FN_ADD,     7'd100, 32'h1234_5678, 8'd0);
    send_req(FN_ADD,     7'd1,   32'h0000_0000, 8'd0);
    send_req(FN_ADD,     7'd0,   32'hffff_ffff, 8'hff);
    send_req(FN_ADD,     7'd1,   32'h8000_0001, 8'd0);
    send_req(FN_ADD,     7'd5,   32'h5555_aaaa, 8'd0);
    send_req(FN_SUBTREE, 7'd0,   32'h0000_0000, 8'd0);
    send_req(FN_CHILD,   7'd1,   32'h0000_0000, 8'd0);
    send_req(FN_CHILD,   7'd1,   32'h0000_0000, 8'd1);
    send_req(FN_CHILD,   7'd1,   32'h0000_0000, 8'd3);
    send_req(FN_CHILD,   7'd0,   32'h0000_0000, 8'd63);
    send_req(FN_CHILD,   7'd0,   32'h0000_0000, CUR_NONE);
    send_req(FN_CHILD,   7'd0,   32'h0000_0000, 8'h80);
    send_req(FN_CHILD,   7'd0,   32'h0000_0000, 8'd64);
    send_req(FN_CHILD,   7'd127, 32'h0000_0000, 8'd127);
    send_req(FN_PARENT,  7'd2,   32'h0000_0000, 8'd0);
    send_req(FN_UNDEF_LO, 7'd0,  32'h0000_0000, 8'd0);
    send_req(FN_UNDEF_HI, 7'd1,  32'hffff_ffff, 8'hff);
    send_req(FN_PRUNE,   7'd1,   32'h0000_0000, 8'd0);
    send_req(FN_ADD,     7'd63,  32'hdead_beef, 8'd0);
    send_req(FN_PARENT,  7'd0,   32'h0000_0000, 8'd0);
    send_req(FN_PRUNE,   7'd0,   32'h0000_0000, 8'd0);

    run_random(200);
    wait_for_drain();

    src_idle_pct  = 74;
    sink_idle_pct = 29;
    run_random(200);
    wait_for_drain();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_random(200);
    wait_for_drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
